>>> rtl/rpc_pkg.sv
`default_nettype none

package rpc_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int XY_W           = 32;
    localparam int IDX_W          = 8;
    localparam int COUNT_W        = 9;
    localparam int UPC_W          = 4;

    // request actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;

    // microprogram addresses
    localparam logic [UPC_W-1:0] UPC_WAIT     = 4'd0;
    localparam logic [UPC_W-1:0] UPC_DISPATCH = 4'd1;
    localparam logic [UPC_W-1:0] UPC_CHECK    = 4'd2;
    localparam logic [UPC_W-1:0] UPC_RD_B     = 4'd3;
    localparam logic [UPC_W-1:0] UPC_LD_B     = 4'd4;
    localparam logic [UPC_W-1:0] UPC_SCAN     = 4'd5;
    localparam logic [UPC_W-1:0] UPC_EMIT     = 4'd6;
    localparam logic [UPC_W-1:0] UPC_NONQ     = 4'd7;
    localparam logic [UPC_W-1:0] UPC_EXEC     = 4'd8;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [XY_W-1:0]  point_x;
        logic signed [XY_W-1:0]  point_y;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        second_index;
    } rpc_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] inside_count;
        logic [1:0]         status;
    } rpc_out_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_REQ,
        C_NOT_QUERY,
        C_BAD_INDEX,
        C_UNUSED,
        C_MORE,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        RA_A,
        RA_B,
        RA_I
    } ra_t;

    typedef struct packed {
        cond_t            cond;
        logic [UPC_W-1:0] target;
        logic             hold;
        logic             in_ready;
        ra_t              ra_sel;
        logic             chk;
        logic             ld_ca;
        logic             ld_cb;
        logic             scan;
        logic             i_inc;
        logic             exec;
        logic             emit;
    } rpc_cw_t;

    typedef struct packed {
        logic not_query;
        logic unused;
        logic bad_index;
        logic more;
        logic out_free;
    } rpc_flags_t;

    // control store
    function automatic rpc_cw_t rpc_rom(input logic [UPC_W-1:0] upc);
        rpc_cw_t cw;
        cw = '0;
        cw.cond   = C_ALWAYS;
        cw.target = UPC_WAIT;
        cw.ra_sel = RA_I;
        unique case (upc)
            UPC_WAIT: begin
                cw.cond     = C_REQ;
                cw.target   = UPC_DISPATCH;
                cw.hold     = 1'b1;
                cw.in_ready = 1'b1;
            end
            UPC_DISPATCH: begin
                cw.cond   = C_NOT_QUERY;
                cw.target = UPC_NONQ;
            end
            UPC_CHECK: begin
                cw.cond   = C_BAD_INDEX;
                cw.target = UPC_EMIT;
                cw.chk    = 1'b1;
                cw.ra_sel = RA_A;
            end
            UPC_RD_B: begin
                cw.cond   = C_ALWAYS;
                cw.target = UPC_LD_B;
                cw.ra_sel = RA_B;
                cw.ld_ca  = 1'b1;
            end
            UPC_LD_B: begin
                cw.target = UPC_SCAN;
                cw.ra_sel = RA_I;
                cw.ld_cb  = 1'b1;
                cw.i_inc  = 1'b1;
            end
            UPC_SCAN: begin
                cw.cond   = C_MORE;
                cw.target = UPC_SCAN;
                cw.ra_sel = RA_I;
                cw.scan   = 1'b1;
                cw.i_inc  = 1'b1;
            end
            UPC_EMIT: begin
                cw.cond   = C_OUT_FREE;
                cw.target = UPC_WAIT;
                cw.hold   = 1'b1;
                cw.emit   = 1'b1;
            end
            UPC_NONQ: begin
                cw.cond   = C_UNUSED;
                cw.target = UPC_WAIT;
            end
            UPC_EXEC: begin
                cw.target = UPC_EMIT;
                cw.exec   = 1'b1;
            end
            default: begin
                cw.target = UPC_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rpc_ram.sv
`default_nettype none

module rpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/rpc_seq.sv
`default_nettype none

module rpc_seq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire rpc_pkg::rpc_flags_t flags,
    output rpc_pkg::rpc_cw_t         cw
);

    logic [rpc_pkg::UPC_W-1:0] upc_reg;
    logic [rpc_pkg::UPC_W-1:0] upc_next;
    logic                      cond_hit;

    assign cw = rpc_pkg::rpc_rom(upc_reg);

    always_comb begin
        unique case (cw.cond)
            rpc_pkg::C_ALWAYS:    cond_hit = 1'b1;
            rpc_pkg::C_REQ:       cond_hit = s_valid;
            rpc_pkg::C_NOT_QUERY: cond_hit = flags.not_query;
            rpc_pkg::C_BAD_INDEX: cond_hit = flags.bad_index;
            rpc_pkg::C_UNUSED:    cond_hit = flags.unused;
            rpc_pkg::C_MORE:      cond_hit = flags.more;
            rpc_pkg::C_OUT_FREE:  cond_hit = flags.out_free;
            default:              cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        if (cond_hit) begin
            upc_next = cw.target;
        end else if (cw.hold) begin
            upc_next = upc_reg;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= rpc_pkg::UPC_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/rpc_dp.sv
`default_nettype none

module rpc_dp #(
    parameter int MAX_POINTS = rpc_pkg::MAX_POINTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire rpc_pkg::rpc_in_t  s_data,
    input  wire rpc_pkg::rpc_cw_t  cw,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output rpc_pkg::rpc_out_t      m_data,
    output rpc_pkg::rpc_flags_t    flags
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CMP_W  = (CNT_W > rpc_pkg::IDX_W) ? CNT_W : rpc_pkg::IDX_W;
    localparam int XY_W   = rpc_pkg::XY_W;

    rpc_pkg::rpc_in_t            req_reg;
    logic [CNT_W-1:0]            fill_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic signed [XY_W-1:0]      ca_x_reg;
    logic signed [XY_W-1:0]      ca_y_reg;
    logic signed [XY_W-1:0]      lox_reg;
    logic signed [XY_W-1:0]      hix_reg;
    logic signed [XY_W-1:0]      loy_reg;
    logic signed [XY_W-1:0]      hiy_reg;
    logic [rpc_pkg::COUNT_W-1:0] res_count_reg;
    logic [1:0]                  res_status_reg;
    logic                        m_valid_reg;
    rpc_pkg::rpc_out_t           m_data_reg;

    logic [CMP_W-1:0]      a_ext;
    logic [CMP_W-1:0]      b_ext;
    logic [CMP_W-1:0]      fill_ext;
    logic                  full;
    logic                  out_free;
    logic                  out_load;
    logic                  ram_we;
    logic [ADDR_W-1:0]     raddr;
    logic [2*XY_W-1:0]     rdata;
    logic signed [XY_W-1:0] rd_x;
    logic signed [XY_W-1:0] rd_y;
    logic                  in_rect;

    assign a_ext    = CMP_W'(req_reg.first_index);
    assign b_ext    = CMP_W'(req_reg.second_index);
    assign fill_ext = CMP_W'(fill_reg);
    assign full     = (fill_reg == CNT_W'(MAX_POINTS));
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = cw.emit && out_free;
    assign ram_we   = cw.exec && (req_reg.action == rpc_pkg::ACT_ADD) && !full;

    assign rd_x = rdata[2*XY_W-1:XY_W];
    assign rd_y = rdata[XY_W-1:0];

    assign in_rect = (rd_x >= lox_reg) && (rd_x <= hix_reg) &&
                     (rd_y >= loy_reg) && (rd_y <= hiy_reg);

    assign flags.not_query = (req_reg.action != rpc_pkg::ACT_QUERY);
    assign flags.unused    = (req_reg.action == rpc_pkg::ACT_NONE);
    assign flags.bad_index = (a_ext >= fill_ext) || (b_ext >= fill_ext);
    assign flags.more      = (idx_reg < fill_reg);
    assign flags.out_free  = out_free;

    always_comb begin
        unique case (cw.ra_sel)
            rpc_pkg::RA_A: raddr = a_ext[ADDR_W-1:0];
            rpc_pkg::RA_B: raddr = b_ext[ADDR_W-1:0];
            rpc_pkg::RA_I: raddr = idx_reg[ADDR_W-1:0];
            default:       raddr = idx_reg[ADDR_W-1:0];
        endcase
    end

    rpc_ram #(
        .WIDTH(2 * XY_W),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(fill_reg[ADDR_W-1:0]),
        .wdata({req_reg.point_x, req_reg.point_y}),
        .raddr(raddr),
        .rdata(rdata)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        if (cw.ld_ca) begin
            ca_x_reg <= rd_x;
            ca_y_reg <= rd_y;
        end
        // order the corners per axis
        if (cw.ld_cb) begin
            lox_reg <= (rd_x < ca_x_reg) ? rd_x : ca_x_reg;
            hix_reg <= (rd_x < ca_x_reg) ? ca_x_reg : rd_x;
            loy_reg <= (rd_y < ca_y_reg) ? rd_y : ca_y_reg;
            hiy_reg <= (rd_y < ca_y_reg) ? ca_y_reg : rd_y;
        end
        if (cw.chk) begin
            res_status_reg <= flags.bad_index ? rpc_pkg::ST_NOT_LOADED : rpc_pkg::ST_OK;
            res_count_reg  <= '0;
        end else if (cw.exec) begin
            res_status_reg <= (req_reg.action == rpc_pkg::ACT_ADD && full) ?
                              rpc_pkg::ST_FULL : rpc_pkg::ST_OK;
            res_count_reg  <= '0;
        end else if (cw.scan) begin
            res_count_reg <= res_count_reg + rpc_pkg::COUNT_W'(in_rect);
        end
        if (cw.chk) begin
            idx_reg <= '0;
        end else if (cw.i_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (out_load) begin
            m_data_reg.inside_count <= res_count_reg;
            m_data_reg.status       <= res_status_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cw.exec && req_reg.action == rpc_pkg::ACT_CLEAR) begin
                fill_reg <= '0;
            end else if (ram_we) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/rectangle_point_count.sv
// rectangle_point_count: holds up to MAX_POINTS signed 2-D points and counts
// points inside the rectangle spanned by two of them.
// Request channel s_valid/s_ready/s_data: action 0 clears the set, 1 adds
// (point_x, point_y), 2 queries with first_index and second_index, 3 is
// dropped without a result. Every other request gives one result on
// m_valid/m_ready/m_data (inside_count, status).
// Control is a nine-step microprogram in a ROM; the datapath keeps the
// points in one single-port-read RAM and scans it one point per cycle.
// Once a request is taken, clear and add pass dispatch, the non-query step,
// exec and emit; a query passes dispatch, the index check, both corner
// reads, the scan over the loaded points and emit, and goes from the check
// straight to emit when an index is not loaded. One request is worked at a
// time; s_ready is high only while the sequencer waits, so a new request
// is taken only after the previous one has gone back to wait.
// The result register frees the sequencer: it returns to wait once the
// result is loaded, and only stalls at its next result while m_valid is
// still held by a slow receiver.
// Reset empties the set and drops any pending result; point storage is
// not cleared and needs no clearing pass.
`default_nettype none

module rectangle_point_count #(
    parameter int MAX_POINTS = rpc_pkg::MAX_POINTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rpc_pkg::rpc_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rpc_pkg::rpc_out_t      m_data
);

    rpc_pkg::rpc_cw_t    cw;
    rpc_pkg::rpc_flags_t flags;
    logic                accept;

    assign s_ready = cw.in_ready;
    assign accept  = s_valid && s_ready;

    rpc_seq u_seq (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .flags  (flags),
        .cw     (cw)
    );

    rpc_dp #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .s_data (s_data),
        .cw     (cw),
        .m_ready(m_ready),
        .m_valid(m_valid),
        .m_data (m_data),
        .flags  (flags)
    );

    // a taken request keeps the sequencer busy for the next cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while previous one still in work");

    // an emit step with a free output register must present a result
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cw.emit && flags.out_free |=> m_valid)
        else $error("emit step did not load the result register");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == rpc_pkg::ST_OK ||
                     m_data.status == rpc_pkg::ST_NOT_LOADED ||
                     m_data.status == rpc_pkg::ST_FULL))
        else $error("result status code out of range");

    a_err_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != rpc_pkg::ST_OK |-> m_data.inside_count == '0)
        else $error("failed request carries a nonzero count");

endmodule

`default_nettype wire
